/* rtl/core/lmld_pkg.sv */
// Shared types and constants for the L2 MAC learn decision unit.
`default_nettype none

package lmld_pkg;

  // Field widths
  localparam int unsigned PortW       = 16;
  localparam int unsigned MinuteW     = 8;
  localparam int unsigned SeqW        = 16;
  localparam int unsigned FlagsW      = 5;
  localparam int unsigned MacW        = 48;
  localparam int unsigned BdW         = 16;
  localparam int unsigned EventW      = 4;
  localparam int unsigned LearnLimitW = 24;
  localparam int unsigned BurstW      = 8;
  localparam int unsigned CfgIdxW     = 1;

  // Learned-entry counter width default
  localparam int unsigned LearnCountBitsDef = 24;

  // Register reset values
  localparam logic [LearnLimitW-1:0] LearnLimitRst = 24'h10_0000;

  // Burst throttle: refreshes above this count are skipped for one-minute-old stamps
  localparam logic [BurstW-1:0] BurstThresh = 8'd2;
  localparam logic [BurstW-1:0] BurstMax    = 8'hFF;

  // Entry flag bit positions
  localparam int unsigned FlgStatic = 0;
  localparam int unsigned FlgFilter = 1;
  localparam int unsigned FlgAgeNot = 2;
  localparam int unsigned FlgLrnEvt = 3;
  localparam int unsigned FlgMovEvt = 4;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEARN_LIMIT = 1'b0,
    CFG_NOTIFY      = 1'b1
  } cfg_idx_e;

  // Event codes
  typedef enum logic [EventW-1:0] {
    EV_UP_TO_DATE   = 4'd0,
    EV_LEARNED      = 4'd1,
    EV_LIMIT        = 4'd2,
    EV_ZERO_MAC     = 4'd3,
    EV_REFRESH      = 4'd4,
    EV_MOVE         = 4'd5,
    EV_FILTER       = 4'd6,
    EV_VIOLATION    = 4'd7,
    EV_REFRESH_SKIP = 4'd8
  } event_e;

  // Lookup class of a request
  typedef enum logic [1:0] {
    KIND_HIT_SAME  = 2'd0,
    KIND_MISS      = 2'd1,
    KIND_HIT_OTHER = 2'd2
  } kind_e;

  // Classified request, as held in the queue
  typedef struct packed {
    logic               frame_start;
    kind_e              kind;
    logic               stale;
    logic               burst_cand;
    logic               zero_mac;
    logic [FlagsW-1:0]  flags;
    logic [PortW-1:0]   rx_port;
    logic [SeqW-1:0]    pkt_seq;
    logic [MacW-1:0]    src_mac;
    logic [BdW-1:0]     bridge_dom;
    logic [MinuteW-1:0] now_minute;
  } class_t;

  // Configuration registers
  typedef struct packed {
    logic [LearnLimitW-1:0] learn_limit;
    logic                   notify_enable;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/lmld_front.sv */
// Front end: classifies each request from its lookup result.
`default_nettype none

module lmld_front
  import lmld_pkg::*;
(
  input  wire logic               frame_start_i,
  input  wire logic [PortW-1:0]   rx_port_i,
  input  wire logic               lookup_hit_i,
  input  wire logic [PortW-1:0]   entry_port_i,
  input  wire logic [MinuteW-1:0] entry_minute_i,
  input  wire logic [SeqW-1:0]    entry_seq_i,
  input  wire logic [FlagsW-1:0]  entry_flags_i,
  input  wire logic [SeqW-1:0]    pkt_seq_i,
  input  wire logic               bd_aging_i,
  input  wire logic [MacW-1:0]    src_mac_i,
  input  wire logic [BdW-1:0]     bridge_dom_i,
  input  wire logic [MinuteW-1:0] now_minute_i,
  output class_t                  class_o
);

  logic [MinuteW-1:0] age;
  logic               seq_old;

  // Age wraps modulo 256
  assign age     = now_minute_i - entry_minute_i;
  assign seq_old = (entry_seq_i != pkt_seq_i);

  always_comb begin
    class_o = '0;
    class_o.frame_start = frame_start_i;
    if (!lookup_hit_i) begin
      class_o.kind = KIND_MISS;
    end else if (entry_port_i == rx_port_i) begin
      class_o.kind = KIND_HIT_SAME;
    end else begin
      class_o.kind = KIND_HIT_OTHER;
    end
    class_o.stale      = ((age != '0) && bd_aging_i) || seq_old;
    class_o.burst_cand = (age == MinuteW'(1)) && !seq_old;
    class_o.zero_mac   = (src_mac_i == '0);
    class_o.flags      = entry_flags_i;
    class_o.rx_port    = rx_port_i;
    class_o.pkt_seq    = pkt_seq_i;
    class_o.src_mac    = src_mac_i;
    class_o.bridge_dom = bridge_dom_i;
    class_o.now_minute = now_minute_i;
  end

endmodule

`default_nettype wire

/* rtl/core/lmld_queue.sv */
// Short queue of classified requests between front and back.
`default_nettype none

module lmld_queue
  import lmld_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  class_t    push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output class_t    head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  class_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill-level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lmld_back.sv */
// Back end: applies counters and limits, builds the result and holds it.
`default_nettype none

module lmld_back
  import lmld_pkg::*;
#(
  parameter int unsigned LearnCountBits = LearnCountBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  cfg_t                    cfg_i,
  input  wire logic               head_valid_i,
  input  class_t                  head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    drop_o,
  output logic                    table_write_o,
  output logic [MacW-1:0]         write_mac_o,
  output logic [BdW-1:0]          write_bd_o,
  output logic [PortW-1:0]        new_port_o,
  output logic [MinuteW-1:0]      new_minute_o,
  output logic [SeqW-1:0]         new_seq_o,
  output logic [FlagsW-1:0]       new_flags_o,
  output logic [EventW-1:0]       event_res_o
);

  localparam int unsigned CmpW =
      (LearnCountBits > LearnLimitW) ? LearnCountBits : LearnLimitW;

  logic [LearnCountBits-1:0] count_q, count_d;
  logic [BurstW-1:0]         burst_q, burst_d;
  logic                      out_valid_q, out_valid_d;

  logic                      drop_q, drop_d;
  logic                      wr_q, wr_d;
  logic [MacW-1:0]           mac_q;
  logic [BdW-1:0]            bd_q;
  logic [PortW-1:0]          port_q, port_d;
  logic [MinuteW-1:0]        minute_q;
  logic [SeqW-1:0]           seq_q;
  logic [FlagsW-1:0]         flags_q, flags_d;
  event_e                    ev_q, ev_d;

  logic [CmpW-1:0]           cnt_ext;
  logic [CmpW-1:0]           lim_ext;
  logic [BurstW-1:0]         burst_cur;
  logic                      cnt_inc;
  logic                      burst_inc;

  assign pop_o   = head_valid_i && (!out_valid_q || !out_stall_i);
  assign cnt_ext = CmpW'(count_q);
  assign lim_ext = CmpW'(cfg_i.learn_limit);
  // A frame start clears the burst count before this request
  assign burst_cur = head_i.frame_start ? '0 : burst_q;

  // Decision
  always_comb begin
    drop_d    = 1'b0;
    wr_d      = 1'b0;
    port_d    = '0;
    flags_d   = '0;
    ev_d      = EV_UP_TO_DATE;
    cnt_inc   = 1'b0;
    burst_inc = 1'b0;
    case (head_i.kind)
      KIND_HIT_SAME: begin
        if (!head_i.stale) begin
          ev_d = EV_UP_TO_DATE;
        end else if (head_i.flags[FlgAgeNot] || (cnt_ext > lim_ext) ||
                     ((burst_cur > BurstThresh) && head_i.burst_cand)) begin
          ev_d = EV_REFRESH_SKIP;
        end else begin
          burst_inc = 1'b1;
          wr_d      = 1'b1;
          port_d    = head_i.rx_port;
          flags_d   = head_i.flags;
          ev_d      = EV_REFRESH;
        end
      end
      KIND_MISS: begin
        if (cnt_ext >= lim_ext) begin
          ev_d = EV_LIMIT;
        end else if (head_i.zero_mac) begin
          ev_d = EV_ZERO_MAC;
        end else begin
          cnt_inc = 1'b1;
          wr_d    = 1'b1;
          port_d  = head_i.rx_port;
          flags_d[FlgLrnEvt] = cfg_i.notify_enable;
          ev_d    = EV_LEARNED;
        end
      end
      KIND_HIT_OTHER: begin
        if (head_i.flags[FlgFilter]) begin
          drop_d = 1'b1;
          ev_d   = EV_FILTER;
        end else if (head_i.flags[FlgStatic]) begin
          drop_d = 1'b1;
          ev_d   = EV_VIOLATION;
        end else begin
          // A moved no-age entry counts as newly learned
          flags_d            = head_i.flags;
          cnt_inc            = head_i.flags[FlgAgeNot];
          flags_d[FlgAgeNot] = 1'b0;
          flags_d[FlgLrnEvt] = cfg_i.notify_enable;
          flags_d[FlgMovEvt] = cfg_i.notify_enable;
          wr_d               = 1'b1;
          port_d             = head_i.rx_port;
          ev_d               = EV_MOVE;
        end
      end
      default: begin
        ev_d = EV_UP_TO_DATE;
      end
    endcase
  end

  // Saturating counters
  always_comb begin
    count_d = count_q;
    burst_d = burst_cur;
    if (cnt_inc && (count_q != '1)) begin
      count_d = count_q + LearnCountBits'(1);
    end
    if (burst_inc && (burst_cur != BurstMax)) begin
      burst_d = burst_cur + BurstW'(1);
    end
  end

  // Output register holds a result while stalled
  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      burst_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        count_q <= count_d;
        burst_q <= burst_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      drop_q   <= drop_d;
      wr_q     <= wr_d;
      mac_q    <= head_i.src_mac;
      bd_q     <= head_i.bridge_dom;
      port_q   <= port_d;
      minute_q <= wr_d ? head_i.now_minute : '0;
      seq_q    <= wr_d ? head_i.pkt_seq : '0;
      flags_q  <= flags_d;
      ev_q     <= ev_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drop_o        = drop_q;
  assign table_write_o = wr_q;
  assign write_mac_o   = mac_q;
  assign write_bd_o    = bd_q;
  assign new_port_o    = port_q;
  assign new_minute_o  = minute_q;
  assign new_seq_o     = seq_q;
  assign new_flags_o   = flags_q;
  assign event_res_o   = ev_q;

endmodule

`default_nettype wire

/* rtl/core/l2_mac_learn_decision_unit.sv */
// Top level of the L2 source-MAC learn decision unit.
`default_nettype none

// Takes one lookup result per cycle for a packet's source MAC and bridge domain and returns
// one decision per request: forward or drop, an optional table write with the new entry,
// and an event code. Sustained rate, unless the output stalls, is one request per clock;
// the front classifies the request into a two-entry queue, and the back, unless stalled,
// pops one entry a cycle into the output register, so a result is registered in the queue
// and then in the output register. The learned count and burst counter live in the back
// and are updated once per popped request. in_stall_o rises only when the queue is full,
// i.e. when the output side has stalled. Configuration writes are always taken (cfg_ready_o
// is high) and must be issued while no request is in flight.
module l2_mac_learn_decision_unit
  import lmld_pkg::*;
#(
  parameter int unsigned LEARN_COUNT_BITS = LearnCountBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [LearnLimitW-1:0] cfg_data_i,
  // Request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               frame_start_i,
  input  wire logic [PortW-1:0]   rx_port_i,
  input  wire logic               lookup_hit_i,
  input  wire logic [PortW-1:0]   entry_port_i,
  input  wire logic [MinuteW-1:0] entry_minute_i,
  input  wire logic [SeqW-1:0]    entry_seq_i,
  input  wire logic [FlagsW-1:0]  entry_flags_i,
  input  wire logic [SeqW-1:0]    pkt_seq_i,
  input  wire logic               bd_aging_i,
  input  wire logic [MacW-1:0]    src_mac_i,
  input  wire logic [BdW-1:0]     bridge_dom_i,
  input  wire logic [MinuteW-1:0] now_minute_i,
  // Result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    drop_o,
  output logic                    table_write_o,
  output logic [MacW-1:0]         write_mac_o,
  output logic [BdW-1:0]          write_bd_o,
  output logic [PortW-1:0]        new_port_o,
  output logic [MinuteW-1:0]      new_minute_o,
  output logic [SeqW-1:0]         new_seq_o,
  output logic [FlagsW-1:0]       new_flags_o,
  output logic [EventW-1:0]       event_res_o
);

  cfg_t   cfg_q, cfg_d;
  class_t front_class;
  class_t head;
  logic   queue_full;
  logic   queue_valid;
  logic   queue_pop;
  logic   in_accept;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LEARN_LIMIT: cfg_d.learn_limit   = cfg_data_i;
        CFG_NOTIFY:      cfg_d.notify_enable = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_limit   <= LearnLimitRst;
      cfg_q.notify_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify
  lmld_front u_front (
    .frame_start_i  (frame_start_i),
    .rx_port_i      (rx_port_i),
    .lookup_hit_i   (lookup_hit_i),
    .entry_port_i   (entry_port_i),
    .entry_minute_i (entry_minute_i),
    .entry_seq_i    (entry_seq_i),
    .entry_flags_i  (entry_flags_i),
    .pkt_seq_i      (pkt_seq_i),
    .bd_aging_i     (bd_aging_i),
    .src_mac_i      (src_mac_i),
    .bridge_dom_i   (bridge_dom_i),
    .now_minute_i   (now_minute_i),
    .class_o        (front_class)
  );

  assign in_stall_o = queue_full;
  assign in_accept  = in_valid_i && !queue_full;

  // Queue between front and back
  lmld_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (front_class),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .head_o      (head)
  );

  // Back: decide and hold result
  lmld_back #(
    .LearnCountBits (LEARN_COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (queue_valid),
    .head_i        (head),
    .pop_o         (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .drop_o        (drop_o),
    .table_write_o (table_write_o),
    .write_mac_o   (write_mac_o),
    .write_bd_o    (write_bd_o),
    .new_port_o    (new_port_o),
    .new_minute_o  (new_minute_o),
    .new_seq_o     (new_seq_o),
    .new_flags_o   (new_flags_o),
    .event_res_o   (event_res_o)
  );

  // Without a table write the entry fields are all zero
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !table_write_o) |->
      (new_port_o == '0) && (new_minute_o == '0) && (new_seq_o == '0) &&
      (new_flags_o == '0))
    else $error("entry fields nonzero without table write");

  // A dropped packet never writes the table
  a_drop_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && drop_o) |-> !table_write_o)
    else $error("drop with table write");

  // Only learn, refresh and move write the table
  a_write_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_write_o) |->
      (event_res_o == EV_LEARNED) || (event_res_o == EV_REFRESH) ||
      (event_res_o == EV_MOVE))
    else $error("table write with wrong event");

  // Write key always follows the popped request: a held result is not replaced
  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(event_res_o) &&
      $stable(write_mac_o)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
